[sv/utf8v_pkg.sv]
package utf8v_pkg;

	// longest run of results one byte can cause
	localparam int unsigned MAX_RUN = 5;
	localparam int unsigned RUN_W   = 3;

	// result kinds
	localparam logic EV_ERROR = 1'b0;
	localparam logic EV_END   = 1'b1;

	// code point limits
	localparam logic [20:0] MIN_LEN2  = 21'h000080;
	localparam logic [20:0] MIN_LEN3  = 21'h000800;
	localparam logic [20:0] MIN_LEN4  = 21'h010000;
	localparam logic [20:0] CODE_MAX  = 21'h10FFFF;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;

	// sequence lengths
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	// open multi-byte sequence
	typedef struct packed {
		logic [1:0]  pend;
		logic [2:0]  len;
		logic [20:0] pv;
	} seq_t;

	// one result transaction
	typedef struct packed {
		logic        event_res;
		logic [31:0] offset;
		logic [31:0] error_total;
	} res_t;

endpackage

[sv/utf8_stream_validator.sv]
// Channel  | Handshake                  | Payload
// item     | item_valid / item_stall    | data_byte, has_byte, end_of_text
// result   | result_valid / result_stall| event_res, offset, error_total, last_of_run
//
// An item is checked in the cycle after it is taken, one item per cycle unless item_stall holds it.
// Its results (up to five) leave the output shift register one per cycle while
// result_stall is low, and an item with several results holds the next one back
// until its last result is leaving; items with none or one result flow freely.
// The first result is offered once the checked item's run is loaded into the output shift register.
// arst_n clears all sequence, offset and error state; no clearing pass is needed.
module utf8_stream_validator
	import utf8v_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_text,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        event_res,
	output logic [31:0] offset,
	output logic [31:0] error_total,
	output logic        last_of_run
);

	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic                   has_byte_s1;
	logic                   end_of_text_s1;
	logic                   adv_s1;
	logic                   rb_free;
	seq_t                   seq_q;
	seq_t                   seq_n;
	logic [OFFSET_BITS-1:0] start_q;
	logic [OFFSET_BITS-1:0] start_n;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] pos_n;
	logic [31:0]            err_q;
	logic [31:0]            err_n;
	logic [RUN_W-1:0]       run_cnt;
	res_t                   run [MAX_RUN];

	assign adv_s1     = valid_s1 && rb_free;
	assign item_stall = valid_s1 && !rb_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			data_byte_s1   <= data_byte;
			has_byte_s1    <= has_byte;
			end_of_text_s1 <= end_of_text;
		end
	end

	// checker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
			err_q   <= '0;
		end else if (adv_s1) begin
			seq_q   <= seq_n;
			start_q <= start_n;
			pos_q   <= pos_n;
			err_q   <= err_n;
		end
	end

	utf8v_check #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_check (
		.data_byte_s1  (data_byte_s1),
		.has_byte_s1   (has_byte_s1),
		.end_of_text_s1(end_of_text_s1),
		.seq_q         (seq_q),
		.start_q       (start_q),
		.pos_q         (pos_q),
		.err_q         (err_q),
		.seq_n         (seq_n),
		.start_n       (start_n),
		.pos_n         (pos_n),
		.err_n         (err_n),
		.run_cnt       (run_cnt),
		.run           (run)
	);

	utf8v_runbuf u_runbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv_s1 && (run_cnt != '0)),
		.run_cnt     (run_cnt),
		.run         (run),
		.free        (rb_free),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.event_res   (event_res),
		.offset      (offset),
		.error_total (error_total),
		.last_of_run (last_of_run)
	);

`ifndef SYNTHESIS
	// an open sequence always has a legal length and room left in it
	a_seq_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q.pend != 2'd0) |-> (((seq_q.len == LEN_2) || (seq_q.len == LEN_3) ||
			(seq_q.len == LEN_4)) && ({1'b0, seq_q.pend} < seq_q.len)))
		else $error("open sequence has bad length or count");

	// no open sequence means cleared sequence state
	a_seq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q.pend == 2'd0) |-> ((seq_q.len == LEN_NONE) && (seq_q.pv == 21'd0)))
		else $error("sequence state left behind");

	// error total only grows within a text
	a_err_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !end_of_text_s1) |=> (err_q >= $past(err_q)))
		else $error("error total went backwards");

	// a byte inside a text moves the position by one unless saturated
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && has_byte_s1 && !end_of_text_s1 && (pos_q != '1))
		|=> (pos_q == ($past(pos_q) + 1'b1)))
		else $error("byte position did not advance");

	// stall only while an item waits in the input register
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid))
		else $error("input stalled with nothing held");
`endif

endmodule

[sv/utf8v_check.sv]
module utf8v_check
	import utf8v_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic [7:0]             data_byte_s1,
	input  logic                   has_byte_s1,
	input  logic                   end_of_text_s1,
	input  seq_t                   seq_q,
	input  logic [OFFSET_BITS-1:0] start_q,
	input  logic [OFFSET_BITS-1:0] pos_q,
	input  logic [31:0]            err_q,
	output seq_t                   seq_n,
	output logic [OFFSET_BITS-1:0] start_n,
	output logic [OFFSET_BITS-1:0] pos_n,
	output logic [31:0]            err_n,
	output logic [RUN_W-1:0]       run_cnt,
	output res_t                   run [MAX_RUN]
);

	// saturating offset increment
	function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] a,
							     input logic [1:0] k);
		logic [OFFSET_BITS:0] s;
		s = {1'b0, a} + {{(OFFSET_BITS-1){1'b0}}, k};
		sat_inc = s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
	endfunction

	// clamp an offset to the 32-bit result field
	function automatic logic [31:0] clamp32(input logic [OFFSET_BITS-1:0] a);
		logic [63:0] w;
		w = 64'(a);
		clamp32 = (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	// saturating error count
	function automatic logic [31:0] err_add(input logic [31:0] a, input logic [2:0] k);
		logic [32:0] s;
		s = {1'b0, a} + 33'(k);
		err_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	seq_t                   seq_a;
	logic [OFFSET_BITS-1:0] start_a;
	logic [OFFSET_BITS-1:0] pos_a;
	logic                   flush1;
	logic                   err1;
	logic                   is_cont;
	logic [20:0]            val;
	logic [20:0]            vmin;
	logic                   bad;
	logic [7:0]             cand_en;
	logic [7:0]             cand_ev;
	logic [31:0]            cand_off [8];
	logic [2:0]             n_all;
	logic [2:0]             n_err;

	assign is_cont = (data_byte_s1[7:6] == 2'b10);
	assign val     = {seq_q.pv[14:0], data_byte_s1[5:0]};
	assign pos_a   = has_byte_s1 ? sat_inc(pos_q, 2'd1) : pos_q;

	always_comb begin
		case (seq_q.len)
			LEN_2:   vmin = MIN_LEN2;
			LEN_3:   vmin = MIN_LEN3;
			default: vmin = MIN_LEN4;
		endcase
	end

	assign bad = (val < vmin) || (val > CODE_MAX) || ((val >= SURR_LO) && (val <= SURR_HI));

	// byte step: continue or close the open sequence, or flush it and open a new one
	always_comb begin
		seq_a   = seq_q;
		start_a = start_q;
		flush1  = 1'b0;
		err1    = 1'b0;
		if (has_byte_s1) begin
			if ((seq_q.pend != 2'd0) && is_cont) begin
				if (({1'b0, seq_q.pend} + 3'd1) >= seq_q.len) begin
					seq_a = '0;
					if (bad) begin
						flush1 = 1'b1;
						err1   = 1'b1;
					end
				end else begin
					seq_a.pend = seq_q.pend + 2'd1;
					seq_a.pv   = val;
				end
			end else begin
				if (seq_q.pend != 2'd0) begin
					flush1 = 1'b1;
					seq_a  = '0;
				end
				case (data_byte_s1) inside
					8'b0???????: begin
					end
					8'b110?????: begin
						seq_a   = '{pend: 2'd1, len: LEN_2, pv: {16'd0, data_byte_s1[4:0]}};
						start_a = pos_q;
					end
					8'b1110????: begin
						seq_a   = '{pend: 2'd1, len: LEN_3, pv: {17'd0, data_byte_s1[3:0]}};
						start_a = pos_q;
					end
					8'b11110???: begin
						seq_a   = '{pend: 2'd1, len: LEN_4, pv: {18'd0, data_byte_s1[2:0]}};
						start_a = pos_q;
					end
					default: err1 = 1'b1;
				endcase
			end
		end
	end

	// candidate results in offset order
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cand_en[i]    = flush1 && (2'(i) < seq_q.pend);
			cand_ev[i]    = EV_ERROR;
			cand_off[i]   = clamp32(sat_inc(start_q, 2'(i)));
			cand_en[4+i]  = end_of_text_s1 && (2'(i) < seq_a.pend);
			cand_ev[4+i]  = EV_ERROR;
			cand_off[4+i] = clamp32(sat_inc(start_a, 2'(i)));
		end
		cand_en[3]  = err1;
		cand_ev[3]  = EV_ERROR;
		cand_off[3] = clamp32(pos_q);
		cand_en[7]  = end_of_text_s1;
		cand_ev[7]  = EV_END;
		cand_off[7] = clamp32(pos_a);
	end

	// pack enabled candidates into the run
	always_comb begin
		n_all = 3'd0;
		n_err = 3'd0;
		for (int k = 0; k < MAX_RUN; k++) begin
			run[k] = '0;
		end
		for (int j = 0; j < 8; j++) begin
			if (cand_en[j]) begin
				if (cand_ev[j] == EV_ERROR) begin
					n_err = n_err + 3'd1;
				end
				if (n_all < 3'(MAX_RUN)) begin
					run[n_all] = '{event_res: cand_ev[j], offset: cand_off[j],
						error_total: err_add(err_q, n_err)};
				end
				n_all = n_all + 3'd1;
			end
		end
	end

	assign run_cnt = n_all;

	// next state; end of text starts a new text
	always_comb begin
		if (end_of_text_s1) begin
			seq_n   = '0;
			start_n = '0;
			pos_n   = '0;
			err_n   = '0;
		end else begin
			seq_n   = seq_a;
			start_n = start_a;
			pos_n   = pos_a;
			err_n   = err_add(err_q, n_err);
		end
	end

endmodule

[sv/utf8v_runbuf.sv]
module utf8v_runbuf
	import utf8v_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [RUN_W-1:0] run_cnt,
	input  res_t             run [MAX_RUN],
	output logic             free,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             event_res,
	output logic [31:0]      offset,
	output logic [31:0]      error_total,
	output logic             last_of_run
);

	res_t             ent_q [MAX_RUN];
	logic [RUN_W-1:0] cnt_q;
	logic             take;

	assign take = (cnt_q != '0) && !result_stall;
	assign free = (cnt_q == '0) || ((cnt_q == RUN_W'(1)) && !result_stall);

	// run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= run_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - RUN_W'(1);
		end
	end

	// shift line, head entry drives the port
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= run;
		end else if (take) begin
			for (int i = 0; i < MAX_RUN - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	assign result_valid = (cnt_q != '0);
	assign event_res    = ent_q[0].event_res;
	assign offset       = ent_q[0].offset;
	assign error_total  = ent_q[0].error_total;
	assign last_of_run  = (cnt_q == RUN_W'(1));

endmodule
